// ----- hdl/frm_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// frm_pkg: shared constants and types of the frame rate meter
// Field widths, ring geometry, digit-serial sizing and divider sizing.
// ---------------------------------------------------------------------------
package frm_pkg;

    localparam int FRAMES       = 16;
    localparam int STAMP_W      = 48;
    localparam int IVL_W        = 24;
    localparam int SUM_W        = IVL_W + $clog2(FRAMES) + 1;
    localparam int RATE_W       = 18;

    localparam int DIGIT_W      = 4;
    localparam int STAMP_DIGITS = STAMP_W / DIGIT_W;
    localparam int IVL_DIGITS   = IVL_W / DIGIT_W;
    localparam int DCNT_W       = $clog2(STAMP_DIGITS);

    localparam int POS_W        = $clog2(FRAMES);
    localparam int FILL_W       = $clog2(FRAMES + 1);

    // 1000 frames per second in Q8
    localparam int RATE_SCALE   = 256000;
    localparam int NUM_W        = $clog2(RATE_SCALE * FRAMES + 1);
    localparam int DIV_CNT_W    = $clog2(NUM_W);

    typedef logic [STAMP_W-1:0] t_stamp;
    typedef logic [IVL_W-1:0]   t_ivl;
    typedef logic [SUM_W-1:0]   t_sum;
    typedef logic [RATE_W-1:0]  t_rate;
    typedef logic [POS_W-1:0]   t_pos;
    typedef logic [FILL_W-1:0]  t_fill;
    typedef logic [NUM_W-1:0]   t_num;
    typedef logic [DCNT_W-1:0]  t_dcnt;
    typedef logic [DIV_CNT_W-1:0] t_div_cnt;

    localparam t_ivl IVL_MAX = '1;

    typedef enum logic {
        CMD_UPDATE = 1'b0,
        CMD_CLEAR  = 1'b1
    } t_cmd;

endpackage

// ----- hdl/frm_in_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// frm_in_if: command channel of the frame rate meter
// Valid/ready channel carrying a command and a millisecond timestamp.
// ---------------------------------------------------------------------------
interface frm_in_if;
    logic                  valid;
    logic                  ready;
    logic                  command;
    frm_pkg::t_stamp       stamp_ms;

    modport source (output valid, output command, output stamp_ms, input ready);
    modport sink   (input valid, input command, input stamp_ms, output ready);
endinterface

// ----- hdl/frm_out_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// frm_out_if: result channel of the frame rate meter
// Valid/ready channel carrying the accept flag and the Q8 frame rate.
// ---------------------------------------------------------------------------
interface frm_out_if;
    logic                  valid;
    logic                  ready;
    logic                  accepted;
    frm_pkg::t_rate        rate_q8;

    modport source (output valid, output accepted, output rate_q8, input ready);
    modport sink   (input valid, input accepted, input rate_q8, output ready);
endinterface

// ----- hdl/frm_div.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// frm_div: serial restoring divider
// One quotient bit per cycle; numerator is the scaled frame count, divisor
// the window sum. Pulses o_done in the cycle after the last step.
// ---------------------------------------------------------------------------
module frm_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  frm_pkg::t_num   i_num,
    input  frm_pkg::t_sum   i_den,
    output logic            o_done,
    output frm_pkg::t_num   o_quot
);

    logic                    r_busy;
    logic                    r_done;
    frm_pkg::t_div_cnt       r_cnt;
    frm_pkg::t_num           r_num;
    frm_pkg::t_num           r_quot;
    frm_pkg::t_sum           r_rem;
    frm_pkg::t_sum           r_den;

    logic [frm_pkg::SUM_W:0] w_trial;
    logic [frm_pkg::SUM_W:0] w_diff;
    logic                    w_ge;

    // bring down the next numerator bit and try the subtraction
    assign w_trial = {r_rem, r_num[frm_pkg::NUM_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_quot <= '0;
            end else if (r_busy) begin
                r_num  <= {r_num[frm_pkg::NUM_W-2:0], 1'b0};
                r_quot <= {r_quot[frm_pkg::NUM_W-2:0], w_ge};
                r_rem  <= w_ge ? w_diff[frm_pkg::SUM_W-1:0] : w_trial[frm_pkg::SUM_W-1:0];
                if (r_cnt == frm_pkg::t_div_cnt'(frm_pkg::NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ----- hdl/frame_rate_meter_core.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// frame_rate_meter_core: moving-average frame rate meter
// Keeps a ring of frame intervals and reports 1000*count/sum in Q8.
// ---------------------------------------------------------------------------
// One beat at a time: a command beat is taken when the meter is idle, its
// 48-bit timestamp is compared with the last accepted one four bits per cycle
// in S_SCAN, the window is updated in S_UPDATE, and the rate comes from a
// one-bit-per-cycle divider (22 steps). The divider is skipped when the
// window is empty or after a clear. A finished result waits in the output
// register while the next beat is accepted. Ring slots are tracked by the fill
// count, so neither reset nor clear sweeps the ring.
module frame_rate_meter_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    frm_in_if.sink      i_in,
    frm_out_if.source   o_out
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE,
        S_PREP,
        S_DIV,
        S_DONE
    } t_state;

    t_state                 r_state;
    logic                   r_enabled;
    logic                   r_cmd;
    frm_pkg::t_stamp        r_stamp;
    frm_pkg::t_stamp        r_last;
    logic                   r_have_prev;
    frm_pkg::t_fill         r_fill;
    frm_pkg::t_pos          r_pos;
    frm_pkg::t_sum          r_sum;
    frm_pkg::t_ivl          r_ring [frm_pkg::FRAMES];
    frm_pkg::t_ivl          r_old;
    frm_pkg::t_dcnt         r_dcnt;
    logic                   r_borrow;
    frm_pkg::t_ivl          r_diff;
    logic                   r_nz;
    logic                   r_hi_nz;
    logic                   r_ok;
    frm_pkg::t_rate         r_rate;
    logic                   r_div_start;
    logic                   r_out_valid;
    logic                   r_out_accepted;
    frm_pkg::t_rate         r_out_rate;

    logic [frm_pkg::DIGIT_W:0] w_dsub;
    logic                   w_gt;
    logic                   w_full;
    logic                   w_take;
    frm_pkg::t_ivl          w_old;
    frm_pkg::t_ivl          w_ivl;
    frm_pkg::t_sum          w_sum_next;
    frm_pkg::t_pos          w_pos_next;
    frm_pkg::t_num          w_num;
    logic                   w_div_done;
    frm_pkg::t_num          w_quot;

    // one digit of stamp - last, least significant first
    assign w_dsub = {1'b0, r_stamp[frm_pkg::DIGIT_W-1:0]}
                  - {1'b0, r_last[frm_pkg::DIGIT_W-1:0]}
                  - {{frm_pkg::DIGIT_W{1'b0}}, r_borrow};

    assign w_gt       = !r_borrow && r_nz;
    assign w_take     = (r_cmd == frm_pkg::CMD_UPDATE) && r_enabled && w_gt;
    assign w_full     = (r_fill == frm_pkg::t_fill'(frm_pkg::FRAMES));
    // a slot not yet written since clear counts as zero
    assign w_old      = w_full ? r_old : '0;
    assign w_ivl      = r_hi_nz ? frm_pkg::IVL_MAX : r_diff;
    assign w_sum_next = r_sum - frm_pkg::t_sum'(w_old) + frm_pkg::t_sum'(w_ivl);
    assign w_pos_next = (r_pos == frm_pkg::t_pos'(frm_pkg::FRAMES - 1)) ? '0 : r_pos + 1'b1;
    assign w_num      = frm_pkg::t_num'(frm_pkg::RATE_SCALE) * frm_pkg::t_num'(r_fill);

    frm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (w_num),
        .i_den   (r_sum),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // the write slot holds still through the scan, so the old entry is ready
    // by the update cycle
    always_ff @(posedge i_clk) begin
        if (r_state == S_UPDATE && w_take && r_have_prev) begin
            r_ring[r_pos] <= w_ivl;
        end
        r_old <= r_ring[r_pos];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_enabled   <= 1'b0;
            r_have_prev <= 1'b0;
            r_fill      <= '0;
            r_pos       <= '0;
            r_sum       <= '0;
            r_last      <= '0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_enabled <= i_cfg_wdata;
            end
            if (r_out_valid && o_out.ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_cmd    <= i_in.command;
                        r_stamp  <= i_in.stamp_ms;
                        r_borrow <= 1'b0;
                        r_nz     <= 1'b0;
                        r_hi_nz  <= 1'b0;
                        r_dcnt   <= '0;
                        r_state  <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // rotate both stamps so they are back in place after a full pass
                    r_stamp  <= {r_stamp[frm_pkg::DIGIT_W-1:0],
                                 r_stamp[frm_pkg::STAMP_W-1:frm_pkg::DIGIT_W]};
                    r_last   <= {r_last[frm_pkg::DIGIT_W-1:0],
                                 r_last[frm_pkg::STAMP_W-1:frm_pkg::DIGIT_W]};
                    r_borrow <= w_dsub[frm_pkg::DIGIT_W];
                    if (w_dsub[frm_pkg::DIGIT_W-1:0] != '0) begin
                        r_nz <= 1'b1;
                    end
                    if (r_dcnt < frm_pkg::t_dcnt'(frm_pkg::IVL_DIGITS)) begin
                        r_diff <= {w_dsub[frm_pkg::DIGIT_W-1:0],
                                   r_diff[frm_pkg::IVL_W-1:frm_pkg::DIGIT_W]};
                    end else if (w_dsub[frm_pkg::DIGIT_W-1:0] != '0) begin
                        r_hi_nz <= 1'b1;
                    end
                    if (r_dcnt == frm_pkg::t_dcnt'(frm_pkg::STAMP_DIGITS - 1)) begin
                        r_state <= S_UPDATE;
                    end else begin
                        r_dcnt <= r_dcnt + 1'b1;
                    end
                end
                S_UPDATE: begin
                    if (r_cmd == frm_pkg::CMD_CLEAR) begin
                        r_fill      <= '0;
                        r_pos       <= '0;
                        r_sum       <= '0;
                        r_have_prev <= 1'b0;
                        r_ok        <= 1'b1;
                    end else if (w_take) begin
                        if (r_have_prev) begin
                            r_sum <= w_sum_next;
                            r_pos <= w_pos_next;
                            if (!w_full) begin
                                r_fill <= r_fill + 1'b1;
                            end
                        end
                        r_last      <= r_stamp;
                        r_have_prev <= 1'b1;
                        r_ok        <= 1'b1;
                    end else begin
                        r_ok <= 1'b0;
                    end
                    r_state <= S_PREP;
                end
                S_PREP: begin
                    if (r_fill == '0) begin
                        r_rate  <= '0;
                        r_state <= S_DONE;
                    end else begin
                        r_div_start <= 1'b1;
                        r_state     <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_div_start <= 1'b0;
                    if (w_div_done) begin
                        r_rate  <= w_quot[frm_pkg::RATE_W-1:0];
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // hold until the output register is free
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid    <= 1'b1;
                        r_out_accepted <= r_ok;
                        r_out_rate     <= r_rate;
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready     = (r_state == S_IDLE);
    assign o_out.valid    = r_out_valid;
    assign o_out.accepted = r_out_accepted;
    assign o_out.rate_q8  = r_out_rate;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= frm_pkg::t_fill'(frm_pkg::FRAMES))
        else $error("fill count beyond ring depth");

    a_pos_tracks_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_full |-> (r_pos == r_fill[frm_pkg::POS_W-1:0]))
        else $error("write position out of step with fill count");

    a_sum_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill == '0) == (r_sum == '0))
        else $error("window sum disagrees with fill count");

    a_accept_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == S_SCAN))
        else $error("accepted beat did not start the stamp scan");

endmodule
